FILE: src/beast_frame_encoder_macros.svh
// Assertion macros used by the frame encoder datapath.
`ifndef BEAST_FRAME_ENCODER_MACROS_SVH
`define BEAST_FRAME_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define BFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bfe assertion failed");
// Antecedent implies consequent in the same cycle.
`define BFE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bfe implication failed");
// Antecedent implies consequent in the next cycle.
`define BFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bfe next-cycle check failed");
`else
`define BFE_ASSERT(lbl, clk, rstn, prop)
`define BFE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define BFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/bfe_pkg.sv
// Shared types and constants of the Beast frame encoder.
`timescale 1ns / 1ps

package bfe_pkg;

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE  = 8'h1a;
    localparam logic [7:0] TYPE_SHORT = 8'h31;
    localparam logic [7:0] TYPE_LONG  = 8'h32;
    localparam logic [7:0] TYPE_EXT   = 8'h33;

    // Message lengths in bytes
    localparam logic [4:0] LEN_SHORT = 5'd2;
    localparam logic [4:0] LEN_LONG  = 5'd7;
    localparam logic [4:0] LEN_EXT   = 5'd14;

    // Byte positions within the frame
    localparam logic [4:0] IDX_SYNC  = 5'd0;
    localparam logic [4:0] IDX_TYPE  = 5'd1;
    localparam logic [4:0] IDX_TS0   = 5'd2;
    localparam logic [4:0] IDX_SIG   = 5'd8;

    // Signal scale: 255^2
    localparam logic [31:0] SIG_SCALE = 32'd65025;

    // Register map
    localparam logic REG_FWD_MLAT = 1'b0;

    // Input bus layout
    localparam int TDATA_W = 184;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic emit;
    } bfe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_ok;
        logic out_free;
        logic byte_avail;
        logic is_last;
    } bfe_sts_t;

endpackage

FILE: src/bfe_sqrt.sv
// Signal byte unit: bit-serial search for round(255 * sqrt(p / 65536)).
`timescale 1ns / 1ps

module bfe_sqrt
    import bfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] power,
    output logic        done,
    output logic [7:0]  result
);

    logic [31:0] rhs_reg;
    logic        nz_reg;
    logic [7:0]  s_reg, s_next;
    logic [2:0]  bit_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [7:0]  cand;
    logic [8:0]  odd;
    logic [17:0] sq;
    logic [31:0] lhs;

    // One result bit per cycle, MSB first
    always_comb
    begin
        cand   = s_reg | (8'd1 << bit_reg);
        odd    = {cand, 1'b0} - 9'd1;
        sq     = 18'(odd) * 18'(odd);
        lhs    = {sq, 14'd0};
        s_next = (lhs <= rhs_reg) ? cand : s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg == 3'd0)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rhs_reg <= 32'(power) * SIG_SCALE;
            nz_reg  <= (power != 16'd0);
            s_reg   <= 8'd0;
            bit_reg <= 3'd7;
        end
        else if (busy_reg)
        begin
            s_reg   <= s_next;
            bit_reg <= bit_reg - 3'd1;
        end
    end

    // Nonzero power never reports zero
    assign done   = done_reg;
    assign result = (nz_reg && s_reg == 8'd0) ? 8'd1 : s_reg;

endmodule

FILE: src/bfe_dp.sv
// Datapath: item capture, frame byte selection, escaping and output register.
`timescale 1ns / 1ps
`include "beast_frame_encoder_macros.svh"

module bfe_dp
    import bfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfe_cmd_t           cmd,
    output bfe_sts_t           sts,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               fwd_mlat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    logic [47:0]  ts_reg;
    logic [111:0] msg_reg;
    logic [7:0]   type_reg;
    logic [4:0]   last_idx_reg;
    logic [4:0]   idx_reg;
    logic         dup_reg;
    logic         m_tvalid_reg;
    logic [7:0]   m_tdata_reg;
    logic         m_tlast_reg;

    logic [4:0]   in_len;
    logic [7:0]   in_type;
    logic         len_ok;
    logic [7:0]   cur_byte;
    logic         esc_needed;
    logic         sq_done;
    logic [7:0]   sq_result;

    bfe_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.capture),
        .power  (s_tdata[71:56]),
        .done   (sq_done),
        .result (sq_result)
    );

    // Length decode and drop check on the incoming item
    always_comb
    begin
        in_len = s_tdata[7:3];
        len_ok = 1'b1;
        case (in_len)
            LEN_SHORT: in_type = TYPE_SHORT;
            LEN_LONG:  in_type = TYPE_LONG;
            LEN_EXT:   in_type = TYPE_EXT;
            default:
            begin
                in_type = TYPE_SHORT;
                len_ok  = 1'b0;
            end
        endcase
    end

    // Byte at the current frame position
    always_comb
    begin
        if (idx_reg == IDX_SYNC)
            cur_byte = SYNC_BYTE;
        else if (idx_reg == IDX_TYPE)
            cur_byte = type_reg;
        else if (idx_reg < IDX_SIG)
            cur_byte = ts_reg[47:40];
        else if (idx_reg == IDX_SIG)
            cur_byte = sq_result;
        else
            cur_byte = msg_reg[111:104];
        esc_needed = (idx_reg >= IDX_TS0) && (cur_byte == SYNC_BYTE) && !dup_reg;
    end

    assign sts.item_ok    = len_ok && !(s_tuser[0] && !fwd_mlat);
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.byte_avail = (idx_reg != IDX_SIG) || sq_done;
    assign sts.is_last    = (idx_reg == last_idx_reg) && !esc_needed;

    // Item fields and frame position; message bytes shift out head first
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ts_reg       <= s_tdata[55:8];
            msg_reg      <= {s_tdata[127:72], s_tdata[183:128]};
            type_reg     <= in_type;
            last_idx_reg <= IDX_SIG + in_len;
            idx_reg      <= IDX_SYNC;
            dup_reg      <= 1'b0;
        end
        else if (cmd.emit)
        begin
            if (esc_needed)
            begin
                dup_reg <= 1'b1;
            end
            else
            begin
                dup_reg <= 1'b0;
                idx_reg <= idx_reg + 5'd1;
                if (idx_reg >= IDX_TS0 && idx_reg < IDX_SIG)
                    ts_reg <= {ts_reg[39:0], 8'd0};
                if (idx_reg > IDX_SIG)
                    msg_reg <= {msg_reg[103:0], 8'd0};
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= sts.is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    `BFE_ASSERT_IMPLY(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
    `BFE_ASSERT_IMPLY(a_sig_ready, clk, rst_n, cmd.emit && idx_reg == IDX_SIG, sq_done)
    `BFE_ASSERT_NEXT(a_esc_copy, clk, rst_n, cmd.emit && esc_needed,
        m_tdata_reg == SYNC_BYTE && !m_tlast_reg)

endmodule

FILE: src/bfe_ctrl.sv
// Controller: takes an item and steps its frame out one byte at a time.
`timescale 1ns / 1ps

module bfe_ctrl
    import bfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output bfe_cmd_t cmd,
    input  bfe_sts_t sts
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Commands and next state
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && sts.item_ok)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.byte_avail)
                begin
                    cmd.emit = 1'b1;
                    if (sts.is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: src/beast_frame_encoder.sv
// Top level of the Beast binary frame encoder.
// Input stream: one received message per item. s_tdata carries the message
// length, timestamp, signal power and message bytes; s_tuser carries the
// multilateration flag. Output stream: the escaped frame, one byte per item,
// m_tlast on the final byte. Register 0 (APB byte address 0) bit 0 enables
// framing of multilateration messages; it resets to 0.
// A new message is taken only when the previous frame has been handed to the
// output register; the last byte of a frame may still wait while the next
// message is accepted. Messages of unsupported length or dropped
// multilateration messages are taken while idle and give no bytes.
// Once a message is accepted, the controller enters its emit state and the
// sync byte is loaded into the output register; a frame of N bytes (11 to 44)
// then goes out one byte per cycle while the receiver does not stall. The
// signal byte comes from a bit-serial square root that finishes before the
// signal byte is due, so it never holds the frame back. When the receiver
// stalls, the output byte holds and the frame pauses. Reset empties the
// output register and returns the controller to idle.
`timescale 1ns / 1ps

module beast_frame_encoder
    import bfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // msg_bits[7:0], timestamp[55:8], signal_power[71:56],
    // msg_head[127:72], msg_tail[183:128]
    input  logic [TDATA_W-1:0] s_tdata,
    // from_mlat[0]
    input  logic [0:0]         s_tuser,
    // Output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_byte[7:0]
    output logic [7:0]         m_tdata,
    // frame_end
    output logic               m_tlast
);

    bfe_cmd_t cmd;
    bfe_sts_t sts;
    logic     fwd_mlat_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_mlat_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_FWD_MLAT)
            fwd_mlat_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FWD_MLAT) ? {31'd0, fwd_mlat_reg} : 32'd0;

    bfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bfe_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fwd_mlat (fwd_mlat_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the Beast binary frame encoder.
`timescale 1ns / 1ps

module tb_top;
    import bfe_pkg::*;

    // One received message as presented on the input stream
    typedef struct packed {
        logic [55:0] tail;
        logic [55:0] head;
        logic [15:0] power;
        logic [47:0] stamp;
        logic [7:0]  msg_bits;
        logic        mlat;
    } beast_msg_t;

    // One byte of an escaped frame
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    localparam int REG_UNUSED = 1;
    localparam int BYTE_WAIT_MAX = 3;
    localparam int SETTLE_CYCLES = 16;

    // Holds the escaped frame bytes still owed by the encoder
    class frame_scoreboard;
        frame_byte_t frame_bytes[$];
        bit fwd_mlat;
        int errors;
        int frames;
        int dropped;
        int bytes_seen;

        // round(255 * sqrt(p / 65536)), at least 1 for nonzero p
        function logic [7:0] signal_level(logic [15:0] p);
            longint unsigned rhs;
            longint unsigned t;
            int count;
            int s;
            rhs = longint'(SIG_SCALE) * longint'(p);
            count = 0;
            for (s = 1; s <= 255; s++)
            begin
                t = longint'(2 * s - 1) * 128;
                if (t * t <= rhs)
                    count++;
                else
                    break;
            end
            if (p != 0 && count < 1)
                count = 1;
            if (count > 255)
                count = 255;
            return count[7:0];
        endfunction

        function void push_byte(logic [7:0] b, bit escape);
            frame_bytes.push_back('{b, 1'b0});
            if (escape && b == SYNC_BYTE)
                frame_bytes.push_back('{SYNC_BYTE, 1'b0});
        endfunction

        // Accepted message: append its escaped frame, if any
        function void note_message(beast_msg_t m);
            logic [4:0] len;
            logic [7:0] kind;
            int i;
            len = m.msg_bits[7:3];
            if (len == LEN_SHORT)
                kind = TYPE_SHORT;
            else if (len == LEN_LONG)
                kind = TYPE_LONG;
            else if (len == LEN_EXT)
                kind = TYPE_EXT;
            else
            begin
                dropped++;
                return;
            end
            if (m.mlat && !fwd_mlat)
            begin
                dropped++;
                return;
            end
            frames++;
            push_byte(SYNC_BYTE, 1'b0);
            push_byte(kind, 1'b0);
            for (i = 0; i < 6; i++)
                push_byte(m.stamp[47 - 8 * i -: 8], 1'b1);
            push_byte(signal_level(m.power), 1'b1);
            for (i = 0; i < int'(len); i++)
            begin
                if (i < 7)
                    push_byte(m.head[55 - 8 * i -: 8], 1'b1);
                else
                    push_byte(m.tail[55 - 8 * (i - 7) -: 8], 1'b1);
            end
            frame_bytes[frame_bytes.size() - 1].last = 1'b1;
        endfunction

        // Output byte: compare with the oldest owed byte
        function void check_byte(logic [7:0] data, logic last);
            frame_byte_t want;
            bytes_seen++;
            if (frame_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte: expected none, actual data %02h last %0b",
                         $time, data, last);
                return;
            end
            want = frame_bytes.pop_front();
            if (data !== want.data)
            begin
                errors++;
                $display("%0t: byte mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: tlast mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;
    logic               m_tlast;

    frame_scoreboard sb = new();
    int msgs_sent;
    bit tx_burst;
    bit rx_burst;

    beast_frame_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast);
    end

    // Receiver: random stall before each byte, with stall-free stretches
    initial
    begin
        int stall;
        int taken;
        m_tready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            rx_burst = ((taken / 100) % 4) == 3;
            stall = rx_burst ? 0 : $urandom_range(0, BYTE_WAIT_MAX);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
            @(negedge clk);
        end
    end

    // APB write: setup then access
    task automatic apb_write(input int index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(4 * index);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input int index, output logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 3'(4 * index);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Wait until every owed byte has left and the encoder is idle
    task automatic drain();
        while (sb.frame_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Read back the forwarding register against the predicted value
    task automatic check_forwarding();
        logic [31:0] rd;
        apb_read(int'(REG_FWD_MLAT), rd);
        if (rd !== {31'd0, sb.fwd_mlat})
        begin
            sb.errors++;
            $display("%0t: register readback: expected %08h, actual %08h",
                     $time, {31'd0, sb.fwd_mlat}, rd);
        end
    endtask

    task automatic set_forwarding(input bit en);
        drain();
        apb_write(int'(REG_FWD_MLAT), {31'($urandom), en});
        sb.fwd_mlat = en;
        check_forwarding();
    endtask

    // Present one message; returns at the falling edge after acceptance
    // with tvalid dropped, so nothing is taken twice
    task automatic send_msg(input beast_msg_t m);
        int gap;
        tx_burst = ((msgs_sent / 40) % 4) == 3;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {m.tail, m.head, m.power, m.stamp, m.msg_bits};
        s_tuser  = m.mlat;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_message(m);
        msgs_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic beast_msg_t mk(logic [7:0] bits, logic [47:0] stamp,
                                      logic [15:0] power, logic mlat,
                                      logic [55:0] head, logic [55:0] tail);
        beast_msg_t m;
        m.msg_bits = bits;
        m.stamp    = stamp;
        m.power    = power;
        m.mlat     = mlat;
        m.head     = head;
        m.tail     = tail;
        return m;
    endfunction

    // Random byte, often the sync value so escaping gets exercised
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0)
            return SYNC_BYTE;
        return 8'($urandom);
    endfunction

    function automatic beast_msg_t rand_msg();
        beast_msg_t m;
        int i;
        int pick;
        for (i = 0; i < 6; i++)
            m.stamp[8 * i +: 8] = rand_byte();
        for (i = 0; i < 7; i++)
        begin
            m.head[8 * i +: 8] = rand_byte();
            m.tail[8 * i +: 8] = rand_byte();
        end
        m.mlat = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            m.power = 16'($urandom_range(0, 800));
        else
            m.power = 16'($urandom);
        // mostly well-formed lengths, some arbitrary ones
        pick = $urandom_range(0, 19);
        if (pick < 6)
            m.msg_bits = 8'(16 + $urandom_range(0, 7));
        else if (pick < 11)
            m.msg_bits = 8'(56 + $urandom_range(0, 7));
        else if (pick < 17)
            m.msg_bits = 8'(112 + $urandom_range(0, 7));
        else
            m.msg_bits = 8'($urandom);
        return m;
    endfunction

    // Main sequence
    initial
    begin
        int phase;
        int k;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        msgs_sent = 0;
        tx_burst  = 1'b0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value of the forwarding register
        sb.fwd_mlat = 1'b0;
        check_forwarding();

        // Directed: field extremes, all lengths, escapes, signal corners
        send_msg(mk(8'd16, 48'h0, 16'h0, 1'b0, 56'h0, 56'h0));
        send_msg(mk(8'd56, {48{1'b1}}, 16'hffff, 1'b0, {56{1'b1}}, {56{1'b1}}));
        send_msg(mk(8'd112, {6{SYNC_BYTE}}, 16'd656, 1'b0, {7{SYNC_BYTE}},
                    {7{SYNC_BYTE}}));
        send_msg(mk(8'd23, 48'h0102_0304_0506, 16'd1, 1'b0, {8'hff, SYNC_BYTE, 40'h0},
                    {56{1'b1}}));
        send_msg(mk(8'd63, 48'h1a00_001a_0000, 16'd2, 1'b0, 56'h0011_2233_4455_66,
                    56'h0));
        send_msg(mk(8'd119, 48'h8000_0000_0001, 16'h8000, 1'b0, 56'h1234_5678_9abc_de,
                    56'hfedc_ba98_7654_1a));
        // unsupported lengths give nothing
        send_msg(mk(8'd0, {48{1'b1}}, 16'hffff, 1'b0, {56{1'b1}}, {56{1'b1}}));
        send_msg(mk(8'd15, 48'h1, 16'h1, 1'b0, 56'h1, 56'h1));
        send_msg(mk(8'd24, 48'h2, 16'h2, 1'b0, 56'h2, 56'h2));
        send_msg(mk(8'd55, 48'h3, 16'h3, 1'b0, 56'h3, 56'h3));
        send_msg(mk(8'd64, 48'h4, 16'h4, 1'b0, 56'h4, 56'h4));
        send_msg(mk(8'd111, 48'h5, 16'h5, 1'b0, 56'h5, 56'h5));
        send_msg(mk(8'd120, 48'h6, 16'h6, 1'b0, 56'h6, 56'h6));
        send_msg(mk(8'd255, 48'h7, 16'h7, 1'b1, 56'h7, 56'h7));
        // multilateration dropped while forwarding is off
        send_msg(mk(8'd112, 48'h9, 16'h900, 1'b1, 56'h9, 56'h9));

        // A write to an unused register index must leave forwarding off
        drain();
        apb_write(REG_UNUSED, 32'hffff_ffff);
        check_forwarding();
        send_msg(mk(8'd56, 48'ha, 16'ha, 1'b1, 56'ha, 56'ha));

        // Forwarding on: multilateration framed
        set_forwarding(1'b1);
        send_msg(mk(8'd16, 48'h0000_1a1a_0000, 16'd655, 1'b1, {SYNC_BYTE, 48'h0},
                    56'h0));
        send_msg(mk(8'd112, 48'hffff_ffff_fffe, 16'd657, 1'b1, {56{1'b1}}, {56{1'b1}}));
        send_msg(mk(8'd58, 48'h0, 16'd3, 1'b0, 56'h1a, 56'h0));

        // Random phases alternating the forwarding setting
        for (phase = 0; phase < 4; phase++)
        begin
            set_forwarding(phase[0]);
            for (k = 0; k < 75; k++)
                send_msg(rand_msg());
        end
        s_tvalid = 1'b0;

        drain();
        repeat (60) @(posedge clk);
        $display("Sent %0d messages: %0d framed, %0d dropped or unsupported.",
                 msgs_sent, sb.frames, sb.dropped);
        $display("Checked %0d frame bytes across both forwarding settings.",
                 sb.bytes_seen);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/bfe_pkg.sv
src/bfe_sqrt.sv
src/bfe_dp.sv
src/bfe_ctrl.sv
src/beast_frame_encoder.sv
tb/tb_top.sv
